>>> hdl/pcbp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types, constants and the prefix code table for the byte packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  localparam int OUT_BITS   = 8;
  localparam int WORK_BITS  = 11;   // widest pending word while an item is worked
  localparam int REST_BITS  = OUT_BITS - 1;
  localparam int FIFO_DEPTH_DEFAULT = 4;

  localparam logic ACTION_ENCODE = 1'b0;
  localparam logic ACTION_FLUSH  = 1'b1;

  localparam logic [7:0] CHAR_A = 8'h61;
  localparam logic [7:0] CHAR_B = 8'h62;
  localparam logic [7:0] CHAR_C = 8'h63;
  localparam logic [7:0] CHAR_D = 8'h64;

  localparam logic [2:0] TERM_CODE = 3'd7;
  localparam logic [2:0] TERM_LEN  = 3'd3;

  typedef struct packed {
    logic [3:0] code;
    logic [2:0] len;
  } code_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] data;
    logic                last;
  } entry_t;

  // results produced by one item: up to two bytes, the second always ends a flush
  typedef struct packed {
    logic [1:0] count;
    entry_t     first;
    entry_t     second;
  } result_pair_t;

  function automatic code_t code_lookup(input logic [7:0] ch);
    code_t c;
    case (ch)
      CHAR_A:  c = '{code: 4'd0,  len: 3'd1};
      CHAR_B:  c = '{code: 4'd2,  len: 3'd2};
      CHAR_C:  c = '{code: 4'd12, len: 3'd4};
      CHAR_D:  c = '{code: 4'd13, len: 3'd4};
      default: c = '{code: 4'd0,  len: 3'd0};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> hdl/pcbp_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_encoder
// Pending bit register and the single-pass code append, byte cut and flush.
// ----------------------------------------------------------------------------
module pcbp_encoder
  import pcbp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         fire,
  input  wire logic         action,
  input  wire logic [7:0]   char_code,
  output result_pair_t      result
);

  localparam logic [3:0] OUT_LEN = 4'(OUT_BITS);

  logic [REST_BITS-1:0] pending_bits;
  logic [2:0]           pending_count;
  logic [REST_BITS-1:0] pending_bits_next;
  logic [2:0]           pending_count_next;

  code_t                sym;
  logic [WORK_BITS-1:0] base;
  logic [WORK_BITS-1:0] work_bits;
  logic [WORK_BITS-1:0] rest_mask;
  logic [3:0]           work_count;
  logic [3:0]           rest;

  always_comb begin
    sym = code_lookup(char_code);
    base = WORK_BITS'(pending_bits);
    if (action == ACTION_FLUSH) begin
      work_bits  = (base << TERM_LEN) | WORK_BITS'(TERM_CODE);
      work_count = 4'(pending_count) + 4'(TERM_LEN);
    end else begin
      work_bits  = (base << sym.len) | WORK_BITS'(sym.code);
      work_count = 4'(pending_count) + 4'(sym.len);
    end
    rest      = work_count - OUT_LEN;
    rest_mask = ~(~WORK_BITS'(0) << rest);

    result             = '0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;

    if (action == ACTION_FLUSH) begin
      pending_bits_next  = '0;
      pending_count_next = '0;
      if (work_count > OUT_LEN) begin
        // terminator spills past one byte: full byte, then the padded tail
        result.count       = 2'd2;
        result.first.data  = OUT_BITS'(work_bits >> rest);
        result.first.last  = 1'b0;
        result.second.data = OUT_BITS'((work_bits & rest_mask) << (OUT_LEN - rest));
        result.second.last = 1'b1;
      end else begin
        result.count      = 2'd1;
        result.first.data = OUT_BITS'(work_bits << (OUT_LEN - work_count));
        result.first.last = 1'b1;
      end
    end else if (work_count >= OUT_LEN) begin
      result.count       = 2'd1;
      result.first.data  = OUT_BITS'(work_bits >> rest);
      result.first.last  = 1'b0;
      pending_bits_next  = REST_BITS'(work_bits & rest_mask);
      pending_count_next = 3'(rest);
    end else begin
      pending_bits_next  = REST_BITS'(work_bits);
      pending_count_next = 3'(work_count);
    end

    if (!fire) begin
      result.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (fire) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/pcbp_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcbp_out_fifo
// Output queue that takes up to two bytes per cycle and hands out one while m_tready is high.
// ----------------------------------------------------------------------------
module pcbp_out_fifo
  import pcbp_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire result_pair_t        push,
  output logic                     room_two,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_BITS-1:0]      m_tdata,   // out_byte
  output logic                     m_tlast    // last
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  entry_t mem [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_1;
  logic [PTR_W-1:0] wr_ptr_2;
  logic [PTR_W-1:0] rd_ptr_next;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  assign wr_ptr_1    = ptr_inc(wr_ptr);
  assign wr_ptr_2    = ptr_inc(wr_ptr_1);
  assign rd_ptr_next = ptr_inc(rd_ptr);
  assign pop         = m_tvalid && m_tready;
  assign m_tvalid    = (count != '0);
  assign m_tdata     = mem[rd_ptr].data;
  assign m_tlast     = mem[rd_ptr].last;
  assign room_two    = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.count)
        2'd1:    wr_ptr <= wr_ptr_1;
        2'd2:    wr_ptr <= wr_ptr_2;
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

>>> hdl/prefix_code_byte_packer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prefix_code_byte_packer
// Packs characters a, b, c, d into a prefix code, MSB-first, one byte at a time.
// ----------------------------------------------------------------------------
// One item is accepted per clock cycle unless the input side stalls. An
// accepted item is held in the input register, where the code append, byte
// cut or flush is worked in a single pass, and its bytes enter the output
// queue; the first byte is offered on m_tvalid the cycle after that. A flush
// with more than five bits pending gives two bytes in the same cycle. Input
// stalls only while the output queue (FIFO_DEPTH entries) has room for fewer
// than two bytes; with an always-ready sink and default depth it never stalls.
module prefix_code_byte_packer
  import pcbp_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // char_code
  input  wire logic                s_tuser,   // action
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OUT_BITS-1:0]      m_tdata,   // out_byte
  output logic                     m_tlast    // last
);

  logic         in_valid;
  logic         in_action;
  logic [7:0]   in_char;
  logic         room_two;
  logic         fire;
  result_pair_t result;

  assign fire     = in_valid && room_two;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_action <= s_tuser;
      in_char   <= s_tdata;
    end
  end

  pcbp_encoder u_encoder (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .action    (in_action),
    .char_code (in_char),
    .result    (result)
  );

  pcbp_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (result),
    .room_two (room_two),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
